// ----- rtl/bdte_pkg.sv -----
// bdte_pkg: shared types, constants and month-length table for
// broken_down_time_to_epoch; no dependencies
package bdte_pkg;

    localparam int LastYear = 2099;

    localparam logic RegZone     = 1'b0;
    localparam logic RegDaylight = 1'b1;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CARRY = 7'b0000010,
        S_YEARS = 7'b0000100,
        S_MONTH = 7'b0001000,
        S_NORM  = 7'b0010000,
        S_SECS  = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    typedef struct packed {
        logic load;
        logic carry;
        logic years;
        logic month;
        logic norm;
        logic secs;
    } t_cmd;

    typedef struct packed {
        logic carry_done;
        logic years_done;
        logic month_done;
        logic norm_done;
        logic secs_done;
    } t_stat;

    // century test by reciprocal: y * 1311 >> 17 is y / 100 for every 12-bit y
    function automatic logic is_leap(input logic [11:0] y);
        logic [22:0] prod;
        logic [5:0]  q;
        logic [11:0] rem;
        prod = 23'(y) * 23'd1311;
        q = prod[22:17];
        rem = y - 12'(q) * 12'd100;
        is_leap = (y[1:0] == 2'd0) && ((rem != 12'd0) || (q[1:0] == 2'd0));
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        case (m)
            4'd1: month_len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10: month_len = 5'd30;
            default: month_len = 5'd31;
        endcase
    endfunction

endpackage

// ----- rtl/broken_down_time_to_epoch.sv -----
// Broken-down time to epoch seconds: one item is taken at a time. Each carry of
// sixty seconds, sixty minutes, twenty-four hours or twelve months is its own step,
// then months and years are walked one a cycle while the day count from 1970 is
// stepped one year a cycle from 1970 alongside. The result word is loaded once the
// receiver has taken the previous one, and only then is a new item taken.
// depends on bdte_pkg, bdte_ctrl and bdte_dp
module broken_down_time_to_epoch (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // second_in, minute_in, hour_in, day_in, month_in, year_in
    input  logic [87:0] s_axis_tdata,
    // dst_flag
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // second_out, minute_out, hour_out, day_out, month_out, year_out,
    // year_day, week_day, epoch_seconds, range_error
    output logic [87:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [4:0]  i_cfg_data
);
    logic [4:0] r_zone;
    logic [1:0] r_dl;
    logic r_valid;
    logic busy, out_load;
    bdte_pkg::t_cmd cmd;
    bdte_pkg::t_stat stat;
    logic [5:0] so, mo; logic [4:0] ho, dyo; logic [3:0] mno; logic [7:0] yo;
    logic [8:0] ydo; logic [2:0] wdo; logic [32:0] eso; logic err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone <= 5'd0;
            r_dl <= 2'd1;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_idx == bdte_pkg::RegZone) r_zone <= i_cfg_data;
            if (i_cfg_we && i_cfg_idx == bdte_pkg::RegDaylight) r_dl <= i_cfg_data[1:0];
            if (out_load) r_valid <= 1'b1;
            else if (m_axis_tready) r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) m_axis_tdata <= {8'd0, err, eso, wdo, ydo, yo, mno, dyo, ho, mo, so};
    end

    assign s_axis_tready = !busy;
    assign m_axis_tvalid = r_valid;

    bdte_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(s_axis_tvalid),
        .i_out_free(!r_valid || m_axis_tready), .i_stat(stat), .o_cmd(cmd),
        .o_busy(busy), .o_out_load(out_load)
    );

    bdte_dp u_dp (
        .i_clk(i_clk), .i_cmd(cmd),
        .i_sec(s_axis_tdata[15:0]), .i_min(s_axis_tdata[31:16]),
        .i_hour(s_axis_tdata[47:32]), .i_day(s_axis_tdata[63:48]),
        .i_mon(s_axis_tdata[71:64]), .i_year(s_axis_tdata[79:72]),
        .i_dst(s_axis_tuser), .i_zone(r_zone), .i_dl(r_dl), .o_stat(stat),
        .o_sec(so), .o_min(mo), .o_hour(ho), .o_day(dyo), .o_mon(mno), .o_year(yo),
        .o_yday(ydo), .o_wday(wdo), .o_secs(eso), .o_err(err)
    );
endmodule

// ----- rtl/bdte_ctrl.sv -----
// bdte_ctrl: sequencer for the conversion steps
// depends on bdte_pkg
module bdte_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_out_free,
    input  bdte_pkg::t_stat i_stat,
    output bdte_pkg::t_cmd  o_cmd,
    output logic           o_busy,
    output logic           o_out_load
);
    bdte_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bdte_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_out_load = 1'b0;
        case (r_state)
            bdte_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state = bdte_pkg::S_CARRY;
                end
            end
            bdte_pkg::S_CARRY: begin
                o_cmd.carry = 1'b1;
                if (i_stat.carry_done) n_state = bdte_pkg::S_YEARS;
            end
            bdte_pkg::S_YEARS: begin
                o_cmd.years = 1'b1;
                if (i_stat.years_done) n_state = bdte_pkg::S_MONTH;
            end
            bdte_pkg::S_MONTH: begin
                o_cmd.month = 1'b1;
                if (i_stat.month_done) n_state = bdte_pkg::S_NORM;
            end
            bdte_pkg::S_NORM: begin
                o_cmd.norm = 1'b1;
                if (i_stat.norm_done) n_state = bdte_pkg::S_SECS;
            end
            bdte_pkg::S_SECS: begin
                o_cmd.secs = 1'b1;
                if (i_stat.secs_done) n_state = bdte_pkg::S_OUT;
            end
            bdte_pkg::S_OUT: begin
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    n_state = bdte_pkg::S_IDLE;
                end
            end
            default: n_state = bdte_pkg::S_IDLE;
        endcase
    end

    assign o_busy = (r_state != bdte_pkg::S_IDLE);

`ifndef ASSERT_OFF
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> !o_busy) else $error("load while busy");
    a_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_load |=> !o_busy) else $error("no return to idle");
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
`endif
endmodule

// ----- rtl/bdte_dp.sv -----
// bdte_dp: datapath; carries time fields, walks years and months, forms seconds
// depends on bdte_pkg
module bdte_dp (
    input  logic            i_clk,
    input  bdte_pkg::t_cmd  i_cmd,
    input  logic [15:0]     i_sec,
    input  logic [15:0]     i_min,
    input  logic [15:0]     i_hour,
    input  logic [15:0]     i_day,
    input  logic [7:0]      i_mon,
    input  logic [7:0]      i_year,
    input  logic            i_dst,
    input  logic [4:0]      i_zone,
    input  logic [1:0]      i_dl,
    output bdte_pkg::t_stat o_stat,
    output logic [5:0]      o_sec,
    output logic [5:0]      o_min,
    output logic [4:0]      o_hour,
    output logic [4:0]      o_day,
    output logic [3:0]      o_mon,
    output logic [7:0]      o_year,
    output logic [8:0]      o_yday,
    output logic [2:0]      o_wday,
    output logic [32:0]     o_secs,
    output logic            o_err
);
    // day count kept relative to the first of January of r_y, then to the start of its month
    logic signed [18:0] r_s, r_m, r_h;
    logic signed [19:0] r_d;
    logic signed [8:0]  r_mo;
    logic [11:0]        r_y;
    logic               r_dst;
    logic signed [4:0]  r_zone;
    logic [1:0]         r_dl;
    logic [3:0]         r_mcnt;
    logic signed [24:0] r_days;
    logic [8:0]         r_yday;
    logic [2:0]         r_wday;
    logic               r_err;
    logic [1:0]         r_ph;
    logic signed [36:0] r_acc;
    logic [8:0]         r_ystart;
    logic signed [24:0] r_ybase;
    logic [11:0]        r_yb_y;

    logic        leap;
    logic [8:0]  ylen;
    logic [4:0]  mlen;
    logic [11:0] ym1;
    logic [8:0]  pylen;
    logic [3:0]  pm;
    logic [4:0]  pmlen;
    logic        yr_fit;
    logic [15:0] wd_num;
    logic [32:0] wd_prod;
    logic [2:0]  wd_rem;

    assign leap  = bdte_pkg::is_leap(r_y);
    assign ylen  = leap ? 9'd366 : 9'd365;
    assign ym1   = r_y - 12'd1;
    assign pylen = bdte_pkg::is_leap(ym1) ? 9'd366 : 9'd365;
    assign mlen  = bdte_pkg::month_len(r_mcnt, leap);
    assign pm    = (r_mcnt == 4'd0) ? 4'd11 : r_mcnt - 4'd1;
    assign pmlen = bdte_pkg::month_len(pm, leap);
    assign yr_fit = (r_d >= 0) && (r_d < $signed({11'd0, ylen}));

    // weekday by reciprocal: x * 74899 >> 19 is x / 7 for every 16-bit x
    assign wd_num  = r_days[15:0] + 16'd4;
    assign wd_prod = {17'd0, wd_num} * 33'd74899;
    assign wd_rem  = 3'(wd_num - 16'(wd_prod[32:19]) * 16'd7);

    always_comb begin
        o_stat.carry_done = (r_s >= 0) && (r_s < 60) && (r_m >= 0) && (r_m < 60)
            && (r_h >= 0) && (r_h < 24) && (r_mo >= 0) && (r_mo < 12);
        o_stat.years_done = yr_fit && (r_mcnt == r_mo[3:0]) && (r_yb_y == r_y);
        o_stat.month_done = (r_mcnt == r_mo[3:0]);
        o_stat.norm_done  = (r_d >= 0) && (r_d < $signed({15'd0, mlen}));
        o_stat.secs_done  = (r_ph == 2'd3);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_s    <= 19'($signed(i_sec));
            r_m    <= 19'($signed(i_min));
            r_h    <= 19'($signed(i_hour));
            r_d    <= 20'($signed(i_day)) - 20'sd1;
            r_mo   <= 9'($signed(i_mon));
            r_y    <= 12'd1900 + {4'd0, i_year};
            r_dst  <= i_dst;
            r_zone <= i_zone;
            r_dl   <= i_dl;
            r_mcnt <= 4'd0;
            r_ph   <= 2'd0;
        end else if (i_cmd.carry) begin
            if (r_s < 0) begin
                r_s <= r_s + 19'sd60; r_m <= r_m - 19'sd1;
            end else if (r_s >= 60) begin
                r_s <= r_s - 19'sd60; r_m <= r_m + 19'sd1;
            end else if (r_m < 0) begin
                r_m <= r_m + 19'sd60; r_h <= r_h - 19'sd1;
            end else if (r_m >= 60) begin
                r_m <= r_m - 19'sd60; r_h <= r_h + 19'sd1;
            end else if (r_h < 0) begin
                r_h <= r_h + 19'sd24; r_d <= r_d - 20'sd1;
            end else if (r_h >= 24) begin
                r_h <= r_h - 19'sd24; r_d <= r_d + 20'sd1;
            end else if (r_mo < 0) begin
                r_mo <= r_mo + 9'sd12; r_y <= r_y - 12'd1;
            end else if (r_mo >= 12) begin
                r_mo <= r_mo - 9'sd12; r_y <= r_y + 12'd1;
            end
            // reset r_mcnt; the years step folds months before r_mo into r_d one by one
            if (o_stat.carry_done) begin
                r_mcnt <= 4'd0;
            end
        end else if (i_cmd.years) begin
            if (r_mcnt != r_mo[3:0]) begin
                r_d <= r_d + 20'($signed({15'd0, mlen}));
                r_mcnt <= r_mcnt + 4'd1;
            end else if (r_d < 0) begin
                r_d <= r_d + 20'($signed({11'd0, pylen}));
                r_y <= ym1;
            end else if (!yr_fit) begin
                r_d <= r_d - 20'($signed({11'd0, ylen}));
                r_y <= r_y + 12'd1;
            end
        end else if (i_cmd.month) begin
            r_mcnt <= 4'd0;
        end else if (i_cmd.norm) begin
            if (r_d >= $signed({15'd0, mlen})) begin
                r_d <= r_d - 20'($signed({15'd0, mlen}));
                r_mcnt <= r_mcnt + 4'd1;
            end
        end else if (i_cmd.secs) begin
            r_ph <= r_ph + 2'd1;
            case (r_ph)
                2'd0: begin
                    r_err <= (r_y < 12'd1970) || (r_y > 12'(bdte_pkg::LastYear));
                    r_yday <= r_ystart + 9'(r_d);
                end
                2'd1: r_acc <= 37'(r_days) * 37'sd86400;
                2'd2: r_acc <= r_acc + 37'(r_h) * 37'sd3600 + 37'(r_m) * 37'sd60 + 37'(r_s)
                    + (37'(r_zone) - 37'($signed({1'b0, r_dst & r_dl[1], r_dst & r_dl[0]})))
                      * 37'sd3600;
                default: ;
            endcase
        end
    end

    // year_day is the sum of lengths of the months already passed plus the day
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ystart <= 9'd0;
        end else if (i_cmd.norm && (r_d >= $signed({15'd0, mlen}))) begin
            r_ystart <= r_ystart + {4'd0, mlen};
        end
    end

    // days from 1970 to Jan 1 of r_y, stepped alongside the year walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ybase <= 25'sd0;
            r_yb_y  <= 12'd1970;
        end else if (r_yb_y < r_y) begin
            r_ybase <= r_ybase + 25'($signed({1'b0, bdte_pkg::is_leap(r_yb_y) ? 9'd366 : 9'd365}));
            r_yb_y  <= r_yb_y + 12'd1;
        end else if (r_yb_y > r_y) begin
            r_ybase <= r_ybase - 25'($signed({1'b0,
                bdte_pkg::is_leap(r_yb_y - 12'd1) ? 9'd366 : 9'd365}));
            r_yb_y  <= r_yb_y - 12'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.secs && r_ph == 2'd0) begin
            r_days <= r_ybase + 25'(r_ystart) + 25'(r_d);
        end
        if (i_cmd.secs && r_ph == 2'd1) begin
            r_wday <= wd_rem;
        end
    end

    always_comb begin
        o_err  = r_err;
        o_sec  = r_err ? '0 : r_s[5:0];
        o_min  = r_err ? '0 : r_m[5:0];
        o_hour = r_err ? '0 : r_h[4:0];
        o_day  = r_err ? '0 : 5'(r_d + 20'sd1);
        o_mon  = r_err ? '0 : r_mcnt;
        o_year = r_err ? '0 : 8'(r_y - 12'd1900);
        o_yday = r_err ? '0 : r_yday;
        o_wday = r_err ? '0 : r_wday;
        o_secs = r_err ? '0 : r_acc[32:0];
    end
endmodule
